// ----- src/tcfd_pkg.sv -----
// shared types and constants of the team command frame decoder
`default_nettype none

package tcfd_pkg;

   // frame layout
   localparam int NUM_ENTRIES_DEF = 6;
   localparam int ENTRY_LEN       = 4;
   localparam logic [7:0] START_BYTE = 8'd100;
   localparam logic [7:0] END_BYTE   = 8'd255;

   // configuration register map
   localparam int         CSR_ADDR_W      = 3;
   localparam logic       CSR_IDX_UNIT_ID = 1'b0;
   localparam logic [3:0] UNIT_ID_RESET   = 4'd8;

   // scaling: q = floor((b * half + 63) / 127), result q - half
   // half is 16 * 1000 for the linear axes, 2 * pi in q12 (25736) for spin
   localparam logic [15:0] VEL_HALF    = 16'd16000;
   localparam logic [15:0] SPIN_HALF   = 16'd25736;
   localparam logic [6:0]  ROUND_BIAS  = 7'd63;
   localparam logic [7:0]  DIVISOR     = 8'd127;
   localparam int          RECIP_SHIFT = 30;
   localparam logic [23:0] RECIP       = 24'd8454660;  // floor(2^30 / 127)
   localparam int          MUL_W       = 24;
   localparam int          MID_W       = 23;
   localparam int          QUO_W       = 17;

   typedef logic [7:0] byte_type;
   typedef logic [ENTRY_LEN-1:0][7:0] entry_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_SHORT     = 2'd1,
      STATUS_BAD_START = 2'd2,
      STATUS_NO_ENTRY  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD  = 2'd0,
      OP_SPAN  = 2'd1,
      OP_RECIP = 2'd2,
      OP_ROUND = 2'd3
   } scale_op_type;

   typedef struct packed {
      scale_op_type op;
      logic         spin;
   } scale_ctrl_type;

   typedef struct packed {
      logic push;
      logic advance;
      logic clear;
   } win_ctrl_type;

endpackage

`default_nettype wire

// ----- src/team_command_frame_decoder_unit.sv -----
// top level of the team command frame decoder: sequencer, csr and result register
`default_nettype none

// Takes received radio bytes one transaction at a time. A data byte (anything
// but 255) is shifted into a window of the last 1 + 4 * NUM_ENTRIES bytes while
// a saturating count tracks bytes since the last terminator. A 255 byte starts
// the frame decode and yields exactly one result transaction: status 1 when
// fewer than a full frame of data bytes arrived, status 2 when the first window
// byte is not 100, status 3 when no entry's low nibble matches the unit id, else
// status 0 with the kick/charge/dribble flags and the three scaled velocities
// (all other fields read zero for a failed frame).
// Handling of a terminator: the edge that takes it moves the sequencer to the
// check state, then the search state scans the entries (the window slides one
// entry per cycle past fixed taps), then each velocity takes a span multiply,
// a reciprocal multiply and a rounding step, since one shared multiplier first
// forms b * half and then multiplies by the reciprocal of 127 before a remainder
// compare rounds. The result loads at the check for a short frame or bad start
// byte, after the last entry when none matches, else after the spin rounding.
// While a terminator is in work req_stall stays high; it also stays high while
// a finished result waits on rsp_stall. The unit id register lives at byte
// address 0 of the csr port and resets to 8.
module team_command_frame_decoder_unit #(
   parameter int NUM_ENTRIES = tcfd_pkg::NUM_ENTRIES_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // request channel
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire  [7:0]                          req_rx_byte,
   // response channel
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_dribble,
   output logic                                rsp_charge,
   output logic                                rsp_kick,
   output logic signed [14:0]                  rsp_x_velocity,
   output logic signed [14:0]                  rsp_y_velocity,
   output logic signed [15:0]                  rsp_spin_rate,
   // csr port
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire  [tcfd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire  [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);
   import tcfd_pkg::*;

   localparam int ENTRY_W = $clog2(NUM_ENTRIES + 1);

   // sequencer states
   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_CHECK     = 6'b000010,
      ST_SEARCH    = 6'b000100,
      ST_MUL_SPAN  = 6'b001000,
      ST_MUL_RECIP = 6'b010000,
      ST_ROUND     = 6'b100000
   } state_type;

   // which velocity the shared unit is working on
   typedef enum logic [1:0] {
      VEL_X    = 2'd0,
      VEL_Y    = 2'd1,
      VEL_SPIN = 2'd2
   } vel_type;

   state_type    state_ff, state_in;
   logic [ENTRY_W-1:0] entry_ff, entry_in;
   vel_type      vel_ff, vel_in;
   logic [ENTRY_LEN-2:0][7:0] opnd_ff, opnd_in;
   logic [3:0]   unit_id_ff, unit_id_in;

   // result register
   logic         valid_ff, valid_in;
   status_type   status_ff, status_in;
   logic         dribble_ff, dribble_in;
   logic         charge_ff, charge_in;
   logic         kick_ff, kick_in;
   logic signed [14:0] xvel_ff, xvel_in;
   logic signed [14:0] yvel_ff, yvel_in;
   logic signed [15:0] spin_ff, spin_in;

   logic           req_fire;
   logic           csr_write;
   win_ctrl_type   win_ctrl;
   scale_ctrl_type scale_ctrl;
   logic           win_full;
   byte_type       win_start;
   entry_type      win_entry;
   logic signed [15:0] scaled;

   tcfd_window #(
      .NUM_ENTRIES (NUM_ENTRIES)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (win_ctrl),
      .byte_in    (req_rx_byte),
      .full       (win_full),
      .start_byte (win_start),
      .entry      (win_entry)
   );

   tcfd_scale u_scale (
      .clock   (clock),
      .ctrl    (scale_ctrl),
      .byte_in (opnd_ff[0]),
      .value   (scaled)
   );

   // csr: single register, pready tied high, byte offset ignored
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unit_id_in = unit_id_ff;
      if (csr_write && (csr_paddr[2] == CSR_IDX_UNIT_ID)) begin
         unit_id_in = csr_pwdata[3:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_IDX_UNIT_ID) ? {28'b0, unit_id_ff} : 32'b0;

   // busy, or a finished result still waits downstream
   assign req_stall = (state_ff != ST_IDLE) || (valid_ff && rsp_stall);
   assign req_fire  = req_valid && !req_stall;

   always_comb begin
      state_in   = state_ff;
      entry_in   = entry_ff;
      vel_in     = vel_ff;
      opnd_in    = opnd_ff;
      valid_in   = valid_ff;
      status_in  = status_ff;
      dribble_in = dribble_ff;
      charge_in  = charge_ff;
      kick_in    = kick_ff;
      xvel_in    = xvel_ff;
      yvel_in    = yvel_ff;
      spin_in    = spin_ff;
      win_ctrl   = '0;
      scale_ctrl.op   = OP_HOLD;
      scale_ctrl.spin = (vel_ff == VEL_SPIN);

      // result taken downstream
      if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_rx_byte == END_BYTE) begin
                  state_in = ST_CHECK;
               end else begin
                  win_ctrl.push = 1'b1;
               end
            end
         end
         ST_CHECK: begin
            // every terminator restarts the count; failed frames read zero
            win_ctrl.clear = 1'b1;
            dribble_in = 1'b0;
            charge_in  = 1'b0;
            kick_in    = 1'b0;
            xvel_in    = '0;
            yvel_in    = '0;
            spin_in    = '0;
            entry_in   = '0;
            if (!win_full) begin
               status_in = STATUS_SHORT;
               valid_in  = 1'b1;
               state_in  = ST_IDLE;
            end else if (win_start != START_BYTE) begin
               status_in = STATUS_BAD_START;
               valid_in  = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (win_entry[0][3:0] == unit_id_ff) begin
               status_in  = STATUS_OK;
               dribble_in = win_entry[0][5];
               charge_in  = win_entry[0][6];
               kick_in    = win_entry[0][7];
               opnd_in    = win_entry[ENTRY_LEN-1:1];
               vel_in     = VEL_X;
               state_in   = ST_MUL_SPAN;
            end else if (entry_ff == ENTRY_W'(NUM_ENTRIES - 1)) begin
               status_in = STATUS_NO_ENTRY;
               valid_in  = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               win_ctrl.advance = 1'b1;
               entry_in = entry_ff + 1'b1;
            end
         end
         ST_MUL_SPAN: begin
            scale_ctrl.op = OP_SPAN;
            state_in = ST_MUL_RECIP;
         end
         ST_MUL_RECIP: begin
            scale_ctrl.op = OP_RECIP;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            scale_ctrl.op = OP_ROUND;
            unique case (vel_ff)
               VEL_X:    xvel_in = scaled[14:0];
               VEL_Y:    yvel_in = scaled[14:0];
               VEL_SPIN: spin_in = scaled;
               default: begin
               end
            endcase
            if (vel_ff == VEL_SPIN) begin
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               vel_in   = (vel_ff == VEL_X) ? VEL_Y : VEL_SPIN;
               opnd_in  = opnd_ff >> 8;
               state_in = ST_MUL_SPAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= 1'b0;
         unit_id_ff <= UNIT_ID_RESET;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         unit_id_ff <= unit_id_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      entry_ff   <= entry_in;
      vel_ff     <= vel_in;
      opnd_ff    <= opnd_in;
      status_ff  <= status_in;
      dribble_ff <= dribble_in;
      charge_ff  <= charge_in;
      kick_ff    <= kick_in;
      xvel_ff    <= xvel_in;
      yvel_ff    <= yvel_in;
      spin_ff    <= spin_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_dribble    = dribble_ff;
   assign rsp_charge     = charge_ff;
   assign rsp_kick       = kick_ff;
   assign rsp_x_velocity = xvel_ff;
   assign rsp_y_velocity = yvel_ff;
   assign rsp_spin_rate  = spin_ff;

   // a terminator always goes to the frame check next
   a_term_to_check: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_rx_byte == END_BYTE)) |=> (state_ff == ST_CHECK))
      else $error("terminator did not start the frame check");

   // a new frame never starts over a result that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> !valid_ff)
      else $error("frame check began with a result still pending");

   // a result only appears at the end of a decode
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(valid_ff) |-> ($past(state_ff) != ST_IDLE))
      else $error("result raised outside a decode");

   // failed frames carry zero flags and velocities
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (status_ff != STATUS_OK)) |->
         (!dribble_ff && !charge_ff && !kick_ff && (xvel_ff == '0) &&
          (yvel_ff == '0) && (spin_ff == '0)))
      else $error("failed frame with nonzero payload");

endmodule

`default_nettype wire

// ----- src/tcfd_window.sv -----
// byte window shift line and saturating data byte count
`default_nettype none

module tcfd_window #(
   parameter int NUM_ENTRIES = tcfd_pkg::NUM_ENTRIES_DEF
) (
   input  wire                      clock,
   input  wire                      reset,
   input  tcfd_pkg::win_ctrl_type   ctrl,
   input  tcfd_pkg::byte_type       byte_in,
   output logic                     full,
   output tcfd_pkg::byte_type       start_byte,
   output tcfd_pkg::entry_type      entry
);
   import tcfd_pkg::*;

   localparam int FRAME_LEN = 1 + ENTRY_LEN * NUM_ENTRIES;
   localparam int CNT_W     = $clog2(FRAME_LEN + 1);

   byte_type         win_ff [FRAME_LEN];
   byte_type         win_in [FRAME_LEN];
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;

   always_comb begin
      win_in = win_ff;
      if (ctrl.push) begin
         for (int i = 0; i < FRAME_LEN - 1; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[FRAME_LEN-1] = byte_in;
      end else if (ctrl.advance) begin
         // next entry slides into the fixed read taps
         for (int i = 0; i < FRAME_LEN - ENTRY_LEN; i++) begin
            win_in[i] = win_ff[i+ENTRY_LEN];
         end
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (ctrl.clear) begin
         cnt_in = '0;
      end else if (ctrl.push && (cnt_ff != CNT_W'(FRAME_LEN))) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_comb begin
      for (int k = 0; k < ENTRY_LEN; k++) begin
         entry[k] = win_ff[1+k];
      end
   end

   assign full       = (cnt_ff == CNT_W'(FRAME_LEN));
   assign start_byte = win_ff[0];

endmodule

`default_nettype wire

// ----- src/tcfd_scale.sv -----
// shared multiplier datapath that scales one byte to fixed point in three steps
`default_nettype none

module tcfd_scale (
   input  wire                      clock,
   input  tcfd_pkg::scale_ctrl_type ctrl,
   input  tcfd_pkg::byte_type       byte_in,
   output logic signed [15:0]       value
);
   import tcfd_pkg::*;

   logic [2*MUL_W-1:0] prod_ff;
   logic [2*MUL_W-1:0] prod_in;
   logic [MID_W-1:0]   mid_ff;
   logic [MID_W-1:0]   mid_in;
   logic [MUL_W-1:0]   mul_a;
   logic [MUL_W-1:0]   mul_b;
   logic [15:0]        half;
   logic [MID_W-1:0]   mid_calc;
   logic [QUO_W-1:0]   quo_est;
   logic [MUL_W-1:0]   quo_times;
   logic [MUL_W-1:0]   rem_full;
   logic [QUO_W-1:0]   quo;

   assign half     = ctrl.spin ? SPIN_HALF : VEL_HALF;
   assign mid_calc = prod_ff[MID_W-1:0] + MID_W'(ROUND_BIAS);

   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      prod_in = prod_ff;
      mid_in  = mid_ff;
      unique case (ctrl.op)
         OP_SPAN: begin
            mul_a   = MUL_W'(byte_in);
            mul_b   = MUL_W'(half);
            prod_in = mul_a * mul_b;
         end
         OP_RECIP: begin
            mul_a   = MUL_W'(mid_calc);
            mul_b   = RECIP;
            prod_in = mul_a * mul_b;
            mid_in  = mid_calc;
         end
         OP_HOLD, OP_ROUND: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      mid_ff  <= mid_in;
   end

   // reciprocal estimate is low by at most one, remainder fixes it
   assign quo_est   = prod_ff[RECIP_SHIFT +: QUO_W];
   assign quo_times = {quo_est, 7'b0} - MUL_W'(quo_est);
   assign rem_full  = MUL_W'(mid_ff) - quo_times;
   assign quo       = quo_est + QUO_W'(rem_full[7:0] >= DIVISOR);
   assign value     = 16'(quo - QUO_W'(half));

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// self-checking testbench for the team command frame decoder unit
`timescale 1ns / 100ps

// Drives radio bytes into the decoder one transaction at a time and keeps its
// own copy of the byte window, the saturating byte count and the unit id. Every
// accepted terminator pushes the predicted command onto a queue, and the
// result monitor compares each accepted result transaction with the oldest
// entry, field by field. The run is a chain of test tasks: frames straight
// after reset, short frame boundaries, value extremes, broken frames, csr
// access, a long receiver hold-off, then random traffic over several robot
// ids, ending with a stretch where neither side idles.
module tb;
   import tcfd_pkg::*;

   // frame geometry and scaling spans
   localparam int FRAME_LEN = 1 + ENTRY_LEN * NUM_ENTRIES_DEF;
   localparam int VEL_SPAN  = 2 * int'(VEL_HALF);
   localparam int SPIN_SPAN = 2 * int'(SPIN_HALF);

   // run control
   localparam int SETTLE_CYCLES = 25;    // outlasts the longest decode
   localparam int DRAIN_LIMIT   = 4000;
   localparam int LONG_HOLD     = 300;
   localparam int RANDOM_BYTES  = 450;
   localparam int CALM_BYTES    = 100;

   // csr map: the unit id at index 0, the next word is an unused slot
   localparam logic [CSR_ADDR_W-1:0] UNIT_ID_ADDR =
      CSR_ADDR_W'(4 * int'(CSR_IDX_UNIT_ID));
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR =
      CSR_ADDR_W'(4 * (int'(CSR_IDX_UNIT_ID) + 1));

   typedef enum {FRAME_OK, FRAME_NO_ENTRY, FRAME_BAD_START, FRAME_SHORT} frame_kind_type;

   typedef struct {
      status_type         status;
      logic               dribble;
      logic               charge;
      logic               kick;
      logic signed [14:0] x_vel;
      logic signed [14:0] y_vel;
      logic signed [15:0] spin;
   } drive_command_type;

   // clock, reset and dut ports, all known from time zero
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_rx_byte = 8'd0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [1:0]            rsp_status;
   logic                  rsp_dribble;
   logic                  rsp_charge;
   logic                  rsp_kick;
   logic signed [14:0]    rsp_x_velocity;
   logic signed [14:0]    rsp_y_velocity;
   logic signed [15:0]    rsp_spin_rate;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = 32'd0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // decoder shadow state
   byte_type          rx_window[FRAME_LEN];
   int                rx_count = 0;
   logic [3:0]        unit_id_shadow = UNIT_ID_RESET;
   drive_command_type pending_commands[$];
   drive_command_type oldest_cmd;

   // stimulus scratch: the six entries of the frame being built
   entry_type frame_slots[NUM_ENTRIES_DEF];

   // idling control
   bit idle_on = 1'b1;      // random bursts allowed on both sides
   bit calm = 1'b0;         // quiet stretch, no bursts
   bit hold_active = 1'b0;  // long receiver hold-off
   int stall_left = 0;
   int calm_left = 0;

   // bookkeeping
   int errors = 0;
   int bytes_sent = 0;
   int results_seen = 0;
   int id_writes = 0;
   int status_count[4] = '{0, 0, 0, 0};

   team_command_frame_decoder_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_dribble    (rsp_dribble),
      .rsp_charge     (rsp_charge),
      .rsp_kick       (rsp_kick),
      .rsp_x_velocity (rsp_x_velocity),
      .rsp_y_velocity (rsp_y_velocity),
      .rsp_spin_rate  (rsp_spin_rate),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // command prediction
   // ---------------------------------------------------------------------

   // linear map of 0..254 onto -span/2..span/2, rounded to nearest
   function automatic int scaled_rate(byte_type b, int span);
      return (int'(b) * span + 127) / 254 - span / 2;
   endfunction

   // data bytes slide into the window, a terminator yields one command
   function automatic void track_rx_byte(byte_type b);
      drive_command_type cmd;
      int                base;
      int                i;
      if (b != END_BYTE) begin
         for (i = 0; i < FRAME_LEN - 1; i++)
            rx_window[i] = rx_window[i + 1];
         rx_window[FRAME_LEN - 1] = b;
         if (rx_count < FRAME_LEN)
            rx_count++;
         return;
      end
      cmd.status  = STATUS_SHORT;
      cmd.dribble = 1'b0;
      cmd.charge  = 1'b0;
      cmd.kick    = 1'b0;
      cmd.x_vel   = '0;
      cmd.y_vel   = '0;
      cmd.spin    = '0;
      if (rx_count < FRAME_LEN) begin
         cmd.status = STATUS_SHORT;
      end else if (rx_window[0] != START_BYTE) begin
         cmd.status = STATUS_BAD_START;
      end else begin
         cmd.status = STATUS_NO_ENTRY;
         // first entry whose low nibble matches wins
         for (i = 0; i < NUM_ENTRIES_DEF; i++) begin
            base = 1 + i * ENTRY_LEN;
            if (cmd.status == STATUS_NO_ENTRY && rx_window[base][3:0] == unit_id_shadow) begin
               cmd.status  = STATUS_OK;
               cmd.dribble = rx_window[base][5];
               cmd.charge  = rx_window[base][6];
               cmd.kick    = rx_window[base][7];
               cmd.x_vel   = 15'(scaled_rate(rx_window[base + 1], VEL_SPAN));
               cmd.y_vel   = 15'(scaled_rate(rx_window[base + 2], VEL_SPAN));
               cmd.spin    = 16'(scaled_rate(rx_window[base + 3], SPIN_SPAN));
            end
         end
      end
      pending_commands.push_back(cmd);
      rx_count = 0;
   endfunction

   // ---------------------------------------------------------------------
   // result monitor: sampled at the falling edge, so the values are the
   // ones the dut presents at the next rising edge where they are taken
   // ---------------------------------------------------------------------

   function automatic void compare_field(string label, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
         errors++;
      end
   endfunction

   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_commands.size() == 0) begin
            $display("%0t: result transaction with no terminator pending, status %0d",
                     $time, rsp_status);
            errors++;
         end else begin
            oldest_cmd = pending_commands.pop_front();
            compare_field("status", int'(oldest_cmd.status), int'(rsp_status));
            compare_field("dribble", int'(oldest_cmd.dribble), int'(rsp_dribble));
            compare_field("charge", int'(oldest_cmd.charge), int'(rsp_charge));
            compare_field("kick", int'(oldest_cmd.kick), int'(rsp_kick));
            compare_field("x_velocity", int'(oldest_cmd.x_vel), int'(rsp_x_velocity));
            compare_field("y_velocity", int'(oldest_cmd.y_vel), int'(rsp_y_velocity));
            compare_field("spin_rate", int'(oldest_cmd.spin), int'(rsp_spin_rate));
            status_count[oldest_cmd.status]++;
            results_seen++;
         end
      end
   end

   // ---------------------------------------------------------------------
   // receiver: random stall bursts, quiet stretches, and the long hold-off
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         calm       <= 1'b0;
         stall_left = 0;
         calm_left  = 0;
      end else begin
         if (calm_left != 0)
            calm_left--;
         else if ($urandom_range(0, 199) == 0)
            calm_left = $urandom_range(30, 120);
         if (stall_left == 0 && idle_on && calm_left == 0 && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 6);
         rsp_stall <= hold_active || (stall_left != 0);
         if (stall_left != 0)
            stall_left--;
         calm <= (calm_left != 0);
      end
   end

   // hold-off counted here while the sender keeps offering bytes
   task automatic hold_receiver(int cycles);
      hold_active <= 1'b1;
      repeat (cycles) @(posedge clock);
      hold_active <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // sender and csr access
   // ---------------------------------------------------------------------

   // offer one byte until taken; valid stays high for a following byte
   task automatic send_byte(byte_type b);
      bit taken;
      if (idle_on && !calm && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      track_rx_byte(b);
      bytes_sent++;
   endtask

   // drop valid, wait out every pending command, then let the dut settle
   task automatic wait_decoder_idle;
      int guard;
      req_valid <= 1'b0;
      guard = 0;
      while (pending_commands.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      if (pending_commands.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, pending_commands.size());
         errors++;
         pending_commands.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [31:0] data);
      bit ready;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      ready = 1'b0;
      while (!ready) begin
         @(negedge clock);
         ready = csr_pready;
         @(posedge clock);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == UNIT_ID_ADDR) begin
         unit_id_shadow = data[3:0];
         id_writes++;
      end
      @(posedge clock);
   endtask

   task automatic csr_read_check;
      logic [31:0] got;
      bit          ready;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= UNIT_ID_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      ready = 1'b0;
      got = '0;
      while (!ready) begin
         @(negedge clock);
         ready = csr_pready;
         got   = csr_prdata;
         @(posedge clock);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      compare_field("unit id readback", int'(unit_id_shadow), int'(got[3:0]));
   endtask

   // ---------------------------------------------------------------------
   // frame building
   // ---------------------------------------------------------------------

   function automatic byte_type rand_data();
      return 8'($urandom_range(0, 254));
   endfunction

   // velocity bytes lean toward the ends of the range
   function automatic byte_type rand_rate_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return 8'd0;
      if (r == 1)
         return 8'd254;
      return rand_data();
   endfunction

   // entry head byte; nibble 15 with high nibble 15 would be a terminator
   function automatic byte_type entry_head(logic [3:0] nibble);
      logic [3:0] hi;
      hi = (nibble == 4'hF) ? 4'($urandom_range(0, 14)) : 4'($urandom_range(0, 15));
      return {hi, nibble};
   endfunction

   function automatic logic [3:0] other_nibble();
      return 4'(int'(unit_id_shadow) + $urandom_range(1, 15));
   endfunction

   function automatic void set_slot(int e, byte_type b0, byte_type b1, byte_type b2,
                                    byte_type b3);
      frame_slots[e][0] = b0;
      frame_slots[e][1] = b1;
      frame_slots[e][2] = b2;
      frame_slots[e][3] = b3;
   endfunction

   // random entries; later entries may match too but must lose to the first
   function automatic void make_random_slots(frame_kind_type kind, int match_slot);
      logic [3:0] nib;
      int         e;
      for (e = 0; e < NUM_ENTRIES_DEF; e++) begin
         if (kind == FRAME_OK && e == match_slot)
            nib = unit_id_shadow;
         else if (kind == FRAME_OK && e > match_slot && $urandom_range(0, 2) == 0)
            nib = unit_id_shadow;
         else if (kind == FRAME_BAD_START)
            nib = 4'($urandom_range(0, 15));
         else
            nib = other_nibble();
         set_slot(e, entry_head(nib), rand_rate_byte(), rand_rate_byte(), rand_rate_byte());
      end
   endfunction

   function automatic byte_type bad_start_byte();
      int v;
      v = $urandom_range(0, 253);
      if (v >= int'(START_BYTE))
         v++;
      return 8'(v);
   endfunction

   // optional leading bytes make a long frame, then start, entries, terminator
   task automatic send_slots(byte_type start, int extra);
      int e;
      int k;
      repeat (extra) send_byte(rand_data());
      send_byte(start);
      for (e = 0; e < NUM_ENTRIES_DEF; e++)
         for (k = 0; k < ENTRY_LEN; k++)
            send_byte(frame_slots[e][k]);
      send_byte(END_BYTE);
   endtask

   task automatic send_frame(frame_kind_type kind, int extra);
      if (kind == FRAME_SHORT) begin
         repeat ($urandom_range(0, FRAME_LEN - 1)) send_byte(rand_data());
         send_byte(END_BYTE);
      end else begin
         make_random_slots(kind, $urandom_range(0, NUM_ENTRIES_DEF - 1));
         send_slots(kind == FRAME_BAD_START ? bad_start_byte() : START_BYTE, extra);
      end
   endtask

   // mostly well-formed frames, the rest broken or cut short
   task automatic send_random_frame;
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         send_frame(FRAME_OK, 0);
      else if (r < 72)
         send_frame(FRAME_NO_ENTRY, 0);
      else if (r < 82)
         send_frame(FRAME_BAD_START, 0);
      else if (r < 92)
         send_frame(FRAME_OK, $urandom_range(1, 30));
      else
         send_frame(FRAME_SHORT, 0);
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // terminators before any full frame, then a frame for the reset unit id
   task automatic test_power_on_frames;
      send_byte(END_BYTE);
      repeat (3) send_byte(rand_data());
      send_byte(END_BYTE);
      send_frame(FRAME_OK, 0);
      wait_decoder_idle();
   endtask

   // one byte short of a frame, exactly a frame, back-to-back terminators
   task automatic test_short_boundaries;
      repeat (FRAME_LEN - 1) send_byte(rand_data());
      send_byte(END_BYTE);
      make_random_slots(FRAME_OK, NUM_ENTRIES_DEF - 1);
      send_slots(START_BYTE, 0);
      send_byte(END_BYTE);
      send_byte(END_BYTE);
      wait_decoder_idle();
   endtask

   // velocity ends and midpoint, all flag bits, both unit id extremes
   task automatic test_value_extremes;
      csr_write(UNIT_ID_ADDR, 32'd0);
      make_random_slots(FRAME_NO_ENTRY, 0);
      set_slot(0, 8'hE0, 8'd0, 8'd254, 8'd0);
      send_slots(START_BYTE, 0);
      wait_decoder_idle();
      // upper bits of the write are dropped, leaving unit id 15
      csr_write(UNIT_ID_ADDR, 32'hFFFF_FFFF);
      make_random_slots(FRAME_NO_ENTRY, 0);
      set_slot(NUM_ENTRIES_DEF - 1, 8'hEF, 8'd254, 8'd0, 8'd254);
      send_slots(START_BYTE, 0);
      make_random_slots(FRAME_NO_ENTRY, 0);
      set_slot(2, 8'h2F, 8'd127, 8'd127, 8'd127);
      send_slots(START_BYTE, 0);
      make_random_slots(FRAME_NO_ENTRY, 0);
      set_slot(1, 8'h4F, 8'd1, 8'd253, 8'd128);
      send_slots(START_BYTE, 0);
      wait_decoder_idle();
   endtask

   // bad start byte, no matching entry, long frame, first match wins
   task automatic test_frame_errors;
      csr_write(UNIT_ID_ADDR, 32'd5);
      make_random_slots(FRAME_OK, 0);
      send_slots(8'd99, 0);
      send_frame(FRAME_BAD_START, 0);
      send_frame(FRAME_NO_ENTRY, 0);
      // leading bytes include a start byte that must slide out of the window
      send_byte(START_BYTE);
      send_frame(FRAME_OK, 9);
      make_random_slots(FRAME_NO_ENTRY, 0);
      set_slot(1, 8'h85, 8'd10, 8'd20, 8'd30);
      set_slot(4, 8'h65, 8'd200, 8'd210, 8'd220);
      send_slots(START_BYTE, 0);
      wait_decoder_idle();
   endtask

   // readback, a write to the unused slot, garbage in the upper bits
   task automatic test_csr_access;
      csr_read_check();
      csr_write(SPARE_ADDR, 32'h0000_000C);
      csr_read_check();
      csr_write(UNIT_ID_ADDR, 32'hABCD_EF02);
      csr_read_check();
      send_frame(FRAME_OK, 0);
      send_frame(FRAME_OK, 0);
      wait_decoder_idle();
   endtask

   // receiver holds off while frames keep coming, so the input backs up
   task automatic test_backpressure;
      fork
         hold_receiver(LONG_HOLD);
      join_none
      repeat (6) send_frame(FRAME_OK, 0);
      send_frame(FRAME_SHORT, 0);
      wait_decoder_idle();
   endtask

   // random frames in phases, unit id changed between phases
   task automatic test_random_traffic;
      int sent_mark;
      int phase;
      sent_mark = bytes_sent;
      phase = 0;
      while (bytes_sent - sent_mark < RANDOM_BYTES) begin
         wait_decoder_idle();
         case (phase % 4)
            0: begin
               csr_write(UNIT_ID_ADDR, $urandom & ~32'hF);
            end
            1: begin
               csr_write(UNIT_ID_ADDR, $urandom | 32'hF);
            end
            default: begin
               csr_write(UNIT_ID_ADDR, $urandom);
            end
         endcase
         phase++;
         repeat (6) send_random_frame();
      end
      wait_decoder_idle();
   endtask

   // last stretch at full rate on both sides
   task automatic test_no_idle;
      int sent_mark;
      idle_on <= 1'b0;
      csr_write(UNIT_ID_ADDR, $urandom);
      sent_mark = bytes_sent;
      while (bytes_sent - sent_mark < CALM_BYTES)
         send_random_frame();
      wait_decoder_idle();
   endtask

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_power_on_frames();
      test_short_boundaries();
      test_value_extremes();
      test_frame_errors();
      test_csr_access();
      test_backpressure();
      test_random_traffic();
      test_no_idle();
      $display("covered %0d radio bytes under %0d unit id writes, %0d frames decoded",
               bytes_sent, id_writes, results_seen);
      $display("frame outcomes: ok %0d, too short %0d, bad start %0d, no entry %0d",
               status_count[STATUS_OK], status_count[STATUS_SHORT],
               status_count[STATUS_BAD_START], status_count[STATUS_NO_ENTRY]);
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("timeout with %0d results pending", pending_commands.size());
      $display("FAIL");
      $finish;
   end

endmodule
